>>> hdl/ledenc_pkg.sv
// ----------------------------------------------------------------------------
// ledenc_pkg
// Shared constants, codes and types of the addressable LED serial encoder.
// ----------------------------------------------------------------------------
package ledenc_pkg;

    localparam int MAX_LEDS         = 16;
    localparam int TICK_COUNT_WIDTH = 16;

    localparam int PIX_AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W   = PIX_AW + 1;
    localparam int PIX_W   = 24;
    localparam int BIT_W   = 5;
    localparam int CFG_W   = 16;
    localparam int LCNT_W  = 5;
    localparam int CIDX_W  = 3;
    localparam int COL_W   = 8;
    localparam int IDX_W   = 8;
    localparam int REQ_W   = 2;

    localparam logic [BIT_W-1:0] BIT_MSB = BIT_W'(PIX_W - 1);

    localparam logic [CFG_W-1:0]  RST_ZERO_HIGH = CFG_W'(4);
    localparam logic [CFG_W-1:0]  RST_ZERO_LOW  = CFG_W'(9);
    localparam logic [CFG_W-1:0]  RST_ONE_HIGH  = CFG_W'(8);
    localparam logic [CFG_W-1:0]  RST_ONE_LOW   = CFG_W'(7);
    localparam logic [CFG_W-1:0]  RST_LATCH_LOW = CFG_W'(600);
    localparam logic [LCNT_W-1:0] RST_LED_COUNT = LCNT_W'(10);

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ZERO_HIGH = 3'd0,
        CFG_ZERO_LOW  = 3'd1,
        CFG_ONE_HIGH  = 3'd2,
        CFG_ONE_LOW   = 3'd3,
        CFG_LATCH_LOW = 3'd4,
        CFG_LED_COUNT = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_HIGH  = 4'b0010,
        PH_LOW   = 4'b0100,
        PH_LATCH = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase                      phase;
        logic [PIX_AW-1:0]           pos;
        logic [BIT_W-1:0]            bitp;
        logic [TICK_COUNT_WIDTH-1:0] ticks;
        logic [PIX_W-1:0]            shift;
    } t_eng;

    typedef struct packed {
        logic data_line;
        logic busy_res;
        logic frame_done;
    } t_res;

endpackage

>>> hdl/ledenc_req_if.sv
// ----------------------------------------------------------------------------
// ledenc_req_if
// Request channel: pixel write, frame start and tick requests.
// ----------------------------------------------------------------------------
interface ledenc_req_if
    import ledenc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] led_index;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;

    modport source (output valid, req_type, led_index, red, green, blue, input ready);
    modport sink   (input valid, req_type, led_index, red, green, blue, output ready);
endinterface

>>> hdl/ledenc_res_if.sv
// ----------------------------------------------------------------------------
// ledenc_res_if
// Result channel: line level, busy and frame done for each request.
// ----------------------------------------------------------------------------
interface ledenc_res_if;
    logic valid;
    logic ready;
    logic data_line;
    logic busy_res;
    logic frame_done;

    modport source (output valid, data_line, busy_res, frame_done, input ready);
    modport sink   (input valid, data_line, busy_res, frame_done, output ready);
endinterface

>>> hdl/ledenc_cfg_if.sv
// ----------------------------------------------------------------------------
// ledenc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ledenc_cfg_if
    import ledenc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CFG_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/addressable_led_serial_encoder_unit.sv
// ----------------------------------------------------------------------------
// addressable_led_serial_encoder_unit
// Results: a taken request's result is registered in the result queue; a tick
// that steps into zero-length phases passes them one phase per cycle first.
// Throughput: one request per cycle; requests are held while such a tick steps
// through its phases and while two results wait in the result queue.
// Reset: synchronous; clears pixel store, sequencer and result queue.
// ----------------------------------------------------------------------------
module addressable_led_serial_encoder_unit
    import ledenc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ledenc_req_if.sink   i_req,
    ledenc_cfg_if.sink   i_cfg,
    ledenc_res_if.source o_res
);

    logic [CFG_W-1:0]  r_zero_high, r_zero_low, r_one_high, r_one_low, r_latch_low;
    logic [LCNT_W-1:0] r_led_count;

    logic [PIX_W-1:0] r_store [MAX_LEDS];

    t_phase                      r_phase;
    logic [PIX_AW-1:0]           r_pos;
    logic [BIT_W-1:0]            r_bitp;
    logic [TICK_COUNT_WIDTH-1:0] r_ticks;
    logic [PIX_W-1:0]            r_shift;
    logic                        r_skip;

    t_res       r_fifo [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    t_eng        cur, adv, sel, n_st;
    logic        adv_fin, n_skip, push, pop, acc, run, wr_en;
    t_res        res;
    t_req        req;
    logic [PIX_AW-1:0] rd_addr;
    logic [PIX_W-1:0]  r_rd_word;
    logic [CNT_W-1:0]  eff_cnt, nxt_pos;

    function automatic logic [TICK_COUNT_WIDTH-1:0] pick(
        input logic bit_val, input logic [CFG_W-1:0] one_v, input logic [CFG_W-1:0] zero_v);
        return bit_val ? TICK_COUNT_WIDTH'(one_v) : TICK_COUNT_WIDTH'(zero_v);
    endfunction

    assign req   = t_req'(i_req.req_type);
    assign i_req.ready = !r_skip && (r_count != 2'd2);
    assign i_cfg.ready = 1'b1;
    assign acc   = i_req.valid && i_req.ready;
    assign run   = r_skip || (acc && req == REQ_TICK);
    assign wr_en = acc && req == REQ_WRITE && 32'(i_req.led_index) < MAX_LEDS;

    assign cur = '{phase: r_phase, pos: r_pos, bitp: r_bitp, ticks: r_ticks, shift: r_shift};

    always_comb begin
        if (r_led_count == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (32'(r_led_count) > MAX_LEDS) begin
            eff_cnt = CNT_W'(MAX_LEDS);
        end else begin
            eff_cnt = CNT_W'(r_led_count);
        end
    end

    assign nxt_pos = {1'b0, r_pos} + CNT_W'(1);
    assign rd_addr = (n_st.phase == PH_IDLE) ? '0 : n_st.pos + PIX_AW'(1);

    // single phase advance
    always_comb begin
        adv     = cur;
        adv_fin = 1'b0;
        unique case (r_phase)
            PH_HIGH: begin
                adv.phase = PH_LOW;
                adv.ticks = pick(r_shift[PIX_W-1], r_one_low, r_zero_low);
            end
            PH_LOW: begin
                if (r_bitp != '0) begin
                    adv.bitp  = r_bitp - BIT_W'(1);
                    adv.shift = {r_shift[PIX_W-2:0], 1'b0};
                    adv.phase = PH_HIGH;
                    adv.ticks = pick(r_shift[PIX_W-2], r_one_high, r_zero_high);
                end else if (nxt_pos < eff_cnt) begin
                    adv.pos   = nxt_pos[PIX_AW-1:0];
                    adv.shift = r_rd_word;
                    adv.bitp  = BIT_MSB;
                    adv.phase = PH_HIGH;
                    adv.ticks = pick(r_rd_word[PIX_W-1], r_one_high, r_zero_high);
                end else begin
                    adv.phase = PH_LATCH;
                    adv.ticks = TICK_COUNT_WIDTH'(r_latch_low);
                end
            end
            PH_LATCH: begin
                adv_fin   = 1'b1;
                adv.phase = PH_IDLE;
                adv.ticks = '0;
            end
            PH_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sel    = (r_ticks == '0) ? adv : cur;
        n_st   = cur;
        n_skip = r_skip;
        push   = 1'b0;
        res    = '0;
        if (run) begin
            if (r_phase == PH_IDLE) begin
                push = 1'b1;
            end else if (r_ticks == '0 && adv_fin) begin
                n_st           = adv;
                n_skip         = 1'b0;
                push           = 1'b1;
                res.busy_res   = 1'b1;
                res.frame_done = 1'b1;
            end else if (r_ticks == '0 && adv.ticks == '0) begin
                n_st   = adv;
                n_skip = 1'b1;
            end else begin
                n_st          = sel;
                n_st.ticks    = sel.ticks - TICK_COUNT_WIDTH'(1);
                n_skip        = 1'b0;
                push          = 1'b1;
                res.busy_res  = 1'b1;
                res.data_line = (sel.phase == PH_HIGH);
                if (sel.phase == PH_LATCH && sel.ticks == TICK_COUNT_WIDTH'(1)) begin
                    n_st.phase     = PH_IDLE;
                    res.frame_done = 1'b1;
                end
            end
        end else if (acc) begin
            push = 1'b1;
            case (req)
                REQ_START: begin
                    res.busy_res = 1'b1;
                    if (r_phase == PH_IDLE) begin
                        n_st.phase = PH_HIGH;
                        n_st.pos   = '0;
                        n_st.bitp  = BIT_MSB;
                        n_st.shift = r_rd_word;
                        n_st.ticks = pick(r_rd_word[PIX_W-1], r_one_high, r_zero_high);
                    end
                end
                default: begin
                    res.busy_res = (r_phase != PH_IDLE);
                end
            endcase
        end
    end

    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_high <= RST_ZERO_HIGH;
            r_zero_low  <= RST_ZERO_LOW;
            r_one_high  <= RST_ONE_HIGH;
            r_one_low   <= RST_ONE_LOW;
            r_latch_low <= RST_LATCH_LOW;
            r_led_count <= RST_LED_COUNT;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ZERO_HIGH: r_zero_high <= i_cfg.data;
                CFG_ZERO_LOW:  r_zero_low  <= i_cfg.data;
                CFG_ONE_HIGH:  r_one_high  <= i_cfg.data;
                CFG_ONE_LOW:   r_one_low   <= i_cfg.data;
                CFG_LATCH_LOW: r_latch_low <= i_cfg.data;
                CFG_LED_COUNT: r_led_count <= i_cfg.data[LCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEDS; i++) begin
                r_store[i] <= '0;
            end
            r_rd_word <= '0;
        end else begin
            if (wr_en) begin
                r_store[PIX_AW'(i_req.led_index)] <= {i_req.green, i_req.red, i_req.blue};
            end
            if (wr_en && PIX_AW'(i_req.led_index) == rd_addr) begin
                r_rd_word <= {i_req.green, i_req.red, i_req.blue};
            end else begin
                r_rd_word <= r_store[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_bitp  <= BIT_MSB;
            r_ticks <= '0;
            r_shift <= '0;
            r_skip  <= 1'b0;
        end else begin
            r_phase <= n_st.phase;
            r_pos   <= n_st.pos;
            r_bitp  <= n_st.bitp;
            r_ticks <= n_st.ticks;
            r_shift <= n_st.shift;
            r_skip  <= n_skip;
        end
    end

    // result queue: hold up to two results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    assign o_res.valid      = (r_count != '0);
    assign o_res.data_line  = r_fifo[r_rd_ptr].data_line;
    assign o_res.busy_res   = r_fifo[r_rd_ptr].busy_res;
    assign o_res.frame_done = r_fifo[r_rd_ptr].frame_done;

`ifndef ASSERT_OFF
    a_skip_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_phase != PH_IDLE && !i_req.ready))
        else $error("skip pass outside a frame");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue overflow");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bitp <= BIT_MSB)
        else $error("bit position out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && res.frame_done) |=> (r_phase == PH_IDLE))
        else $error("frame done without return to idle");

    a_skip_nopush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && n_skip) |-> !push)
        else $error("result pushed during skip pass");
`endif

endmodule
